### rtl/core/cqs_pkg.sv
// Package for the circular queue with search.
// Holds operation and status codes, field widths and defaults shared by all modules.
package cqs_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W = 32;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;
   localparam int POS_W = 4;
   localparam int CNT_W = 5;

   localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

### rtl/core/circular_queue_with_search.sv
// Top level of the circular queue with search: control, pointers and register port.
// Depends on cqs_pkg and instantiates cqs_slot_ram.
//
// A request is taken at a rising edge where start is high and busy is low. It carries
// req_op (enqueue, dequeue, peek, clear or search) and req_value. Exactly one result
// follows on the rsp_ ports, marked by rsp_valid for one cycle; the receiver cannot
// hold it off, so it must take every result as it appears.
// Enqueue, dequeue, peek, clear and unused codes give their result in the cycle after the
// request and leave busy low, so one such request can be taken every cycle.
// Search raises busy and walks the held entries from the oldest, one slot per cycle,
// since each slot comes out of the single read port of the slot memory. Its result
// is registered once a slot matches or the last held slot has been compared (at most
// the count held); a search of an empty queue answers in the cycle after the request.
// The capacity register sits at byte address 0 of the register port. Writing it empties
// the queue; the user must write it only while no request is in flight (not enforced).
// Reset empties the queue and sets capacity to 16 (limited to DEPTH). The slot memory
// is not cleared, since only written slots are ever read.
module circular_queue_with_search #(
   parameter int DEPTH = cqs_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [cqs_pkg::OP_W-1:0]        req_op,
   input  logic signed [cqs_pkg::WORD_W-1:0] req_value,
   output logic                            rsp_valid,
   output logic [cqs_pkg::STATUS_W-1:0]    rsp_status,
   output logic signed [cqs_pkg::WORD_W-1:0] rsp_data,
   output logic [cqs_pkg::POS_W-1:0]       rsp_position,
   output logic [cqs_pkg::CNT_W-1:0]       rsp_count,
   output logic                            rsp_empty_res,
   output logic                            rsp_full_res,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [2:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = cqs_pkg::CNT_W;
   localparam int WW = cqs_pkg::WORD_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic                             state_ff, state_in;
   logic [AW-1:0]                    head_ff, head_in;
   logic [AW-1:0]                    tail_ff, tail_in;
   logic [CW-1:0]                    held_ff, held_in;
   logic [CW-1:0]                    capacity_ff, capacity_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [CW-1:0]                    left_ff, left_in;
   logic [WW-1:0]                    key_ff, key_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [cqs_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [cqs_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic                             empty_ff, empty_in;
   logic                             full_ff, full_in;
   logic                             use_rd_ff, use_rd_in;

   logic [CW-1:0]                    cap_eff;
   logic                             accept;
   logic                             csr_write;
   logic                             wr_en;
   logic [AW-1:0]                    rd_addr;
   logic [WW-1:0]                    rd_data;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                             input logic [CW-1:0] cap);
      logic [31:0] nxt;
      begin
         nxt = 32'(idx) + 32'd1;
         advance = (nxt >= 32'(cap)) ? '0 : AW'(nxt);
      end
   endfunction

   assign cap_eff = (capacity_ff == '0) ? CW'(1) :
                    ((32'(capacity_ff) > 32'(DEPTH)) ? CW'(DEPTH) : capacity_ff);
   assign busy = (state_ff == ST_SEARCH);
   assign accept = start && !busy;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      held_in = held_ff;
      capacity_in = capacity_ff;
      idx_in = idx_ff;
      left_in = left_ff;
      key_in = key_ff;
      rsp_valid_in = 1'b0;
      status_in = cqs_pkg::STATUS_OK;
      pos_in = '0;
      use_rd_in = 1'b0;
      wr_en = 1'b0;
      rd_addr = head_ff;

      if (state_ff == ST_IDLE) begin
         if (accept) begin
            rsp_valid_in = 1'b1;
            case (req_op)
               cqs_pkg::OP_ENQUEUE: begin
                  if (held_ff >= cap_eff) begin
                     status_in = cqs_pkg::STATUS_FULL;
                  end else begin
                     wr_en = 1'b1;
                     tail_in = advance(tail_ff, cap_eff);
                     held_in = held_ff + CW'(1);
                  end
               end
               cqs_pkg::OP_DEQUEUE: begin
                  if (held_ff == '0) begin
                     status_in = cqs_pkg::STATUS_EMPTY;
                  end else begin
                     use_rd_in = 1'b1;
                     head_in = advance(head_ff, cap_eff);
                     held_in = held_ff - CW'(1);
                  end
               end
               cqs_pkg::OP_PEEK: begin
                  if (held_ff == '0) begin
                     status_in = cqs_pkg::STATUS_EMPTY;
                  end else begin
                     use_rd_in = 1'b1;
                  end
               end
               cqs_pkg::OP_CLEAR: begin
                  head_in = '0;
                  tail_in = '0;
                  held_in = '0;
               end
               cqs_pkg::OP_SEARCH: begin
                  if (held_ff == '0) begin
                     status_in = cqs_pkg::STATUS_NOT_FOUND;
                  end else begin
                     rsp_valid_in = 1'b0;
                     state_in = ST_SEARCH;
                     idx_in = head_ff;
                     left_in = held_ff;
                     key_in = req_value;
                  end
               end
               default: begin
               end
            endcase
         end
      end else begin
         if (rd_data == key_ff) begin
            rsp_valid_in = 1'b1;
            pos_in = cqs_pkg::POS_W'(idx_ff);
            state_in = ST_IDLE;
         end else if (left_ff == CW'(1)) begin
            rsp_valid_in = 1'b1;
            status_in = cqs_pkg::STATUS_NOT_FOUND;
            state_in = ST_IDLE;
         end else begin
            idx_in = advance(idx_ff, cap_eff);
            left_in = left_ff - CW'(1);
            rd_addr = advance(idx_ff, cap_eff);
         end
      end

      if (csr_write) begin
         capacity_in = pwdata[CW-1:0];
         head_in = '0;
         tail_in = '0;
         held_in = '0;
      end

      count_in = held_in;
      empty_in = (held_in == '0);
      full_in = (held_in == cap_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         held_ff <= '0;
         capacity_ff <= cqs_pkg::CAPACITY_RESET;
         left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         held_ff <= held_in;
         capacity_ff <= capacity_in;
         left_ff <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      key_ff <= key_in;
      status_ff <= status_in;
      pos_ff <= pos_in;
      count_ff <= count_in;
      empty_ff <= empty_in;
      full_ff <= full_in;
      use_rd_ff <= use_rd_in;
   end

   cqs_slot_ram #(
      .DEPTH(DEPTH)
   ) u_slot_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(tail_ff),
      .wr_data(req_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_data = use_rd_ff ? rd_data : '0;
   assign rsp_position = pos_ff;
   assign rsp_count = count_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_full_res = full_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? 32'(capacity_ff) : '0;

`ifndef SYNTHESIS
   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap_eff)
      else $error("Entry count exceeds the effective capacity.");

   a_pointers_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(head_ff) < 32'(cap_eff)) && (32'(tail_ff) < 32'(cap_eff)))
      else $error("Head or tail pointer lies beyond the effective capacity.");

   a_pointers_meet: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0 || held_ff == cap_eff) |-> head_ff == tail_ff)
      else $error("Head and tail differ while the queue is empty or full.");

   a_simple_op_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op != cqs_pkg::OP_SEARCH) |=> rsp_valid)
      else $error("No result one cycle after a non-search request.");

   a_empty_status_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cqs_pkg::STATUS_EMPTY) |-> rsp_count == '0)
      else $error("Empty status reported with a nonzero count.");
`endif

endmodule

### rtl/core/cqs_slot_ram.sv
// Slot storage of the circular queue: one write port, one registered read port.
// Depends on cqs_pkg for the word width and the default depth.
module cqs_slot_ram #(
   parameter int DEPTH = cqs_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [cqs_pkg::WORD_W-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [cqs_pkg::WORD_W-1:0]    rd_data
);

   logic [cqs_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [cqs_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
